FILE: rtl/core/descriptor_slot_allocator_core_macros.svh
// Assertion helpers shared by the allocator RTL.
// Both are clocked on clk_i and stay quiet while rst_ni is low.
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_CORE_MACROS_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_CORE_MACROS_SVH

// Property that must hold at every clock edge.
`define DSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/dsa_pkg.sv
package dsa_pkg;

  localparam int unsigned SLOT_W        = 8;
  localparam int unsigned SLOT_SPACE    = 1 << SLOT_W;
  localparam int unsigned CNT_W         = 9;
  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned SIZE_W        = 13;
  localparam int unsigned KIND_W        = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned PROD_W        = SLOT_W + SIZE_W;
  localparam int unsigned DEF_MAX_SLOTS = 256;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
  localparam logic [CNT_W-1:0]  CAP_RESET  = CNT_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPU_BASE  = 2'd0,
    CFG_GPU_BASE  = 2'd1,
    CFG_DESC_SIZE = 2'd2,
    CFG_CAPACITY  = 2'd3
  } cfg_idx_e;

endpackage

FILE: rtl/core/dsa_ram.sv
module dsa_ram
  import dsa_pkg::*;
#(
  parameter int unsigned Width = SLOT_W,
  parameter int unsigned Depth = DEF_MAX_SLOTS
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/descriptor_slot_allocator_core.sv
// Each accepted item passes through the input register and then the result register.
// Throughput: one item per cycle unless the output stalls; every kind takes one pass.
// The free stack keeps its top in a register and prefetches the next entry from the RAM.
// Reset: counts and free marks clear, config registers load defaults; no clearing pass.
// Free stack storage is not initialized; only entries below the stack top are read.
`include "descriptor_slot_allocator_core_macros.svh"
module descriptor_slot_allocator_core
  import dsa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = DEF_MAX_SLOTS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [KIND_W-1:0]     kind_i,
  input  logic [SLOT_W-1:0]     free_index_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SLOT_W-1:0]     slot_index_o,
  output logic [ADDR_W-1:0]     cpu_address_o,
  output logic [ADDR_W-1:0]     gpu_address_o,
  output logic [CNT_W-1:0]      in_use_count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned SLOT_LIMIT = (MAX_SLOTS < SLOT_SPACE) ? MAX_SLOTS : SLOT_SPACE;
  localparam int unsigned AW         = $clog2(SLOT_LIMIT);
  localparam logic [CNT_W-1:0] LIMIT = CNT_W'(SLOT_LIMIT);

  // configuration
  logic [ADDR_W-1:0] cpu_base_q, gpu_base_q;
  logic [SIZE_W-1:0] desc_size_q;
  logic [CNT_W-1:0]  capacity_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_base_q  <= '0;
      gpu_base_q  <= '0;
      desc_size_q <= SIZE_RESET;
      capacity_q  <= CAP_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_CPU_BASE:  cpu_base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_GPU_BASE:  gpu_base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_DESC_SIZE: desc_size_q <= cfg_data_i[SIZE_W-1:0];
        CFG_CAPACITY:  capacity_q  <= cfg_data_i[CNT_W-1:0];
      endcase
    end
  end

  // input register
  logic              s1_valid_q, s1_valid_d;
  logic [KIND_W-1:0] s1_kind_q;
  logic [SLOT_W-1:0] s1_index_q;
  logic              out_valid_q, out_valid_d;
  logic              advance, in_fire, proc;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;
  assign proc       = s1_valid_q && advance;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= kind_i;
      s1_index_q <= free_index_i;
    end
  end

  // allocator state
  logic [CNT_W-1:0]      free_top_q, free_top_d;
  logic [CNT_W-1:0]      high_water_q, high_water_d;
  logic [CNT_W-1:0]      used_q, used_d;
  logic [SLOT_LIMIT-1:0] free_mark_q, free_mark_d;
  logic [SLOT_W-1:0]     top_q, top_d;
  logic [SLOT_W-1:0]     ram_rdata;
  logic [CNT_W-1:0]      rd_ptr;
  logic                  ram_we;

  logic [CNT_W-1:0]  eff_cap;
  logic              idx_ok, mark_hit, grant;
  logic [SLOT_W-1:0] slot;
  status_e           status;

  assign eff_cap  = (capacity_q < LIMIT) ? capacity_q : LIMIT;
  assign idx_ok   = {1'b0, s1_index_q} < LIMIT;
  assign mark_hit = free_mark_q[s1_index_q[AW-1:0]];

  always_comb begin
    free_top_d   = free_top_q;
    high_water_d = high_water_q;
    used_d       = used_q;
    free_mark_d  = free_mark_q;
    top_d        = top_q;
    ram_we       = 1'b0;
    grant        = 1'b0;
    slot         = '0;
    status       = ST_OK;
    if (proc) begin
      unique case (kind_e'(s1_kind_q))
        KIND_ALLOC: begin
          if (used_q >= eff_cap) begin
            status = ST_FULL;
          end else begin
            grant = 1'b1;
            if (free_top_q != '0) begin
              // pop: the prefetched second entry becomes the new top
              free_top_d                   = free_top_q - CNT_W'(1);
              slot                         = top_q;
              free_mark_d[top_q[AW-1:0]]   = 1'b0;
              top_d                        = ram_rdata;
            end else begin
              slot         = high_water_q[SLOT_W-1:0];
              high_water_d = high_water_q + CNT_W'(1);
            end
            used_d = used_q + CNT_W'(1);
          end
        end
        KIND_FREE: begin
          if (!idx_ok || ({1'b0, s1_index_q} >= high_water_q) || mark_hit ||
              (free_top_q >= LIMIT) || (used_q == '0)) begin
            status = ST_ALREADY_FREE;
          end else begin
            ram_we                           = 1'b1;
            free_top_d                       = free_top_q + CNT_W'(1);
            free_mark_d[s1_index_q[AW-1:0]]  = 1'b1;
            used_d                           = used_q - CNT_W'(1);
            top_d                            = s1_index_q;
          end
        end
        KIND_CLEAR: begin
          free_top_d   = '0;
          high_water_d = '0;
          used_d       = '0;
          free_mark_d  = '0;
        end
        KIND_NOP: begin
        end
      endcase
    end
  end

  // prefetch the entry just below the next top
  assign rd_ptr = free_top_d - CNT_W'(2);

  dsa_ram #(
    .Width(SLOT_W),
    .Depth(SLOT_LIMIT)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_top_q[AW-1:0]),
    .wdata_i(s1_index_q),
    .raddr_i(rd_ptr[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_top_q   <= '0;
      high_water_q <= '0;
      used_q       <= '0;
      free_mark_q  <= '0;
    end else begin
      free_top_q   <= free_top_d;
      high_water_q <= high_water_d;
      used_q       <= used_d;
      free_mark_q  <= free_mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q <= top_d;
  end

  // result register
  logic [PROD_W-1:0]   offset;
  logic [STATUS_W-1:0] status_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [ADDR_W-1:0]   cpu_addr_q, gpu_addr_q;
  logic [CNT_W-1:0]    count_q;

  assign offset = slot * desc_size_q;

  always_comb begin
    if (proc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      status_q   <= status;
      slot_q     <= slot;
      cpu_addr_q <= grant ? (cpu_base_q + ADDR_W'(offset)) : '0;
      gpu_addr_q <= grant ? (gpu_base_q + ADDR_W'(offset)) : '0;
      count_q    <= used_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign cpu_address_o  = cpu_addr_q;
  assign gpu_address_o  = gpu_addr_q;
  assign in_use_count_o = count_q;

  // every slot below the high-water mark is either held or waiting on the stack
  `DSA_ASSERT(a_count_balance, ({1'b0, used_q} + {1'b0, free_top_q}) == {1'b0, high_water_q}, "used plus free does not match high-water mark")
  `DSA_ASSERT(a_hw_bound, high_water_q <= LIMIT, "high-water mark beyond slot limit")
  `DSA_ASSERT(a_mark_count, $countones(free_mark_q) == int'(free_top_q), "free marks disagree with stack depth")
  `DSA_ASSERT_NEXT(a_fail_zero, proc && !grant, (slot_index_o == '0) && (cpu_address_o == '0) && (gpu_address_o == '0), "failed or non-allocate item carries a slot")

endmodule
